>>> rtl/heikin_ashi_rsi_wilder_unit_assert.svh
// ----------------------------------------------------------------------------
// heikin ashi rsi unit assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef HEIKIN_ASHI_RSI_WILDER_UNIT_ASSERT_SVH
`define HEIKIN_ASHI_RSI_WILDER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HARA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hara implication check failed");
`define HARA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hara next cycle check failed");
`else
`define HARA_ASSERT_IMP(lbl, ante, cons)
`define HARA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/hara_pkg.sv
// ----------------------------------------------------------------------------
// hara_pkg
// shared types and constants of the heikin ashi rsi unit
// ----------------------------------------------------------------------------
package hara_pkg;

  localparam int PRICE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int SUM_W      = PRICE_BITS + 2;
  localparam int MOVE_W     = SUM_W + FRAC_BITS;
  localparam int AVG_W      = 57;
  localparam int NORM_BITS  = 48;
  localparam int CNT_W      = 7;
  localparam int REG_W      = 7;
  localparam int RSI_W      = 16;
  localparam int OUT_W      = 15;

  localparam logic [AVG_W-1:0] AVG_MAX      = {AVG_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX    = {CNT_W{1'b1}};
  localparam logic [REG_W-1:0] LEN_RESET    = 7'd14;
  localparam logic [REG_W-1:0] SMO_RESET    = 7'd1;
  localparam logic [REG_W-1:0] REG_MAX      = 7'd100;
  localparam int               RSI_HALF     = 12800;

  localparam logic CFG_RSI_LENGTH     = 1'b0;
  localparam logic CFG_OPEN_SMOOTHING = 1'b1;

  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_ACCUM,
    KIND_INIT,
    KIND_SMOOTH
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SUM_W-1:0]  gain;
    logic [SUM_W-1:0]  loss;
    logic [REG_W-1:0]  n;
    logic [REG_W-1:0]  s;
    logic              open_half;
  } cmd_t;

  function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v);
    logic [REG_W-1:0] r;
    r = v;
    if (v == '0) r = 7'd1;
    else if (v > REG_MAX) r = REG_MAX;
    return r;
  endfunction

  function automatic logic [AVG_W-1:0] sat_avg(input logic [64:0] v);
    logic [AVG_W-1:0] r;
    r = (v > {8'd0, AVG_MAX}) ? AVG_MAX : v[AVG_W-1:0];
    return r;
  endfunction

endpackage

>>> rtl/heikin_ashi_rsi_wilder_unit.sv
// ----------------------------------------------------------------------------
// heikin_ashi_rsi_wilder_unit
// wilder rsi of bar price sums drawn as heikin ashi candles, one word per bar
// ----------------------------------------------------------------------------
// flow: warm-up bars go straight to the output word; once the rsi runs the back
//   divides for two averages, normalises, divides for the ratio and, later, the open
// pacing: the back works on one bar at a time and the shared serial divider sets
//   the pace; the queue lets the front take 3 more bars meanwhile
// reset: synchronous active low, clears bar count, averages and open,
//   loads rsi_length 14 and open_smoothing 1
`include "heikin_ashi_rsi_wilder_unit_assert.svh"

module heikin_ashi_rsi_wilder_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hara_pkg::PRICE_BITS-1:0] in_bar_open,
  input  logic [hara_pkg::PRICE_BITS-1:0] in_bar_high,
  input  logic [hara_pkg::PRICE_BITS-1:0] in_bar_low,
  input  logic [hara_pkg::PRICE_BITS-1:0] in_bar_close,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_rsi_valid,
  output logic [hara_pkg::OUT_W-1:0]      out_rsi_open,
  output logic [hara_pkg::OUT_W-1:0]      out_rsi_high,
  output logic [hara_pkg::OUT_W-1:0]      out_rsi_low,
  output logic [hara_pkg::OUT_W-1:0]      out_rsi_close,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [hara_pkg::REG_W-1:0]      cfg_wdata
);

  // front to queue
  logic           push;
  logic           full;
  hara_pkg::cmd_t front_cmd;
  // queue to back
  logic           pop;
  logic           empty;
  hara_pkg::cmd_t back_cmd;

  // front: price sum, move split into gain and loss, bar phase, config
  hara_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_bar_open  (in_bar_open),
    .in_bar_high  (in_bar_high),
    .in_bar_low   (in_bar_low),
    .in_bar_close (in_bar_close),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .full         (full),
    .cmd          (front_cmd)
  );

  // short queue so the front keeps taking bars while the back divides
  hara_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (front_cmd),
    .full    (full),
    .pop     (pop),
    .cmd_out (back_cmd),
    .empty   (empty)
  );

  // back: averages, rsi ratio, smoothed open, candle, output word
  hara_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .cmd           (back_cmd),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rsi_valid (out_rsi_valid),
    .out_rsi_open  (out_rsi_open),
    .out_rsi_high  (out_rsi_high),
    .out_rsi_low   (out_rsi_low),
    .out_rsi_close (out_rsi_close)
  );

  // queue never pushed while full or popped while empty
  `HARA_ASSERT_IMP(a_no_overflow, push, !full)
  `HARA_ASSERT_IMP(a_no_underflow, pop, !empty)
  // warm-up words carry zeros only
  `HARA_ASSERT_IMP(a_warmup_zero, out_valid && !out_rsi_valid,
    out_rsi_open == '0 && out_rsi_high == '0 && out_rsi_low == '0 && out_rsi_close == '0)
  // candle high never below low
  `HARA_ASSERT_IMP(a_high_ge_low, out_valid && out_rsi_valid,
    $signed(out_rsi_high) >= $signed(out_rsi_low))

endmodule

>>> rtl/hara_div.sv
// ----------------------------------------------------------------------------
// hara_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hara_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [63:0]                     num,
  input  logic [hara_pkg::NORM_BITS-1:0]  den,
  input  logic [6:0]                      nbits,
  output logic                            done,
  output logic [63:0]                     quot
);

  logic                           busy_r;
  logic                           done_r;
  logic [6:0]                     cnt_r;
  logic [63:0]                    num_r;
  logic [hara_pkg::NORM_BITS-1:0] den_r;
  logic [hara_pkg::NORM_BITS-1:0] rem_r;
  logic [63:0]                    quot_r;
  logic [6:0]                     pos;
  logic [hara_pkg::NORM_BITS:0]   trial;
  logic                           ge;
  logic [hara_pkg::NORM_BITS-1:0] rem_nxt;

  always_comb begin
    pos     = cnt_r - 7'd1;
    trial   = {rem_r, num_r[pos[5:0]]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? hara_pkg::NORM_BITS'(trial - {1'b0, den_r})
                 : trial[hara_pkg::NORM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      num_r  <= '0;
      den_r  <= '0;
      rem_r  <= '0;
      quot_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        quot_r <= '0;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quot_r <= {quot_r[62:0], ge};
        cnt_r  <= pos;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

>>> rtl/hara_front.sv
// ----------------------------------------------------------------------------
// hara_front
// takes bars, forms price sums and moves, classifies each bar
// ----------------------------------------------------------------------------
module hara_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hara_pkg::PRICE_BITS-1:0]   in_bar_open,
  input  logic [hara_pkg::PRICE_BITS-1:0]   in_bar_high,
  input  logic [hara_pkg::PRICE_BITS-1:0]   in_bar_low,
  input  logic [hara_pkg::PRICE_BITS-1:0]   in_bar_close,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [hara_pkg::REG_W-1:0]        cfg_wdata,
  output logic                              push,
  input  logic                              full,
  output hara_pkg::cmd_t                    cmd
);

  logic                          s1_valid_r;
  logic [hara_pkg::SUM_W-1:0]    sum_r;
  logic [hara_pkg::SUM_W-1:0]    prev_r;
  logic [hara_pkg::CNT_W-1:0]    bar_count_r;
  logic [hara_pkg::REG_W-1:0]    len_r;
  logic [hara_pkg::REG_W-1:0]    smo_r;
  logic [hara_pkg::REG_W-1:0]    n_eff;
  logic [hara_pkg::REG_W-1:0]    s_eff;
  logic [hara_pkg::SUM_W-1:0]    sum_nxt;
  logic                          accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = s1_valid_r && full;
  assign push     = s1_valid_r && !full;

  assign sum_nxt = hara_pkg::SUM_W'(in_bar_open) + hara_pkg::SUM_W'(in_bar_high)
                 + hara_pkg::SUM_W'(in_bar_low)  + hara_pkg::SUM_W'(in_bar_close);

  always_comb begin
    n_eff = hara_pkg::clamp_reg(len_r);
    s_eff = hara_pkg::clamp_reg(smo_r);
    cmd.n = n_eff;
    cmd.s = s_eff;
    cmd.open_half = bar_count_r < s_eff;
    if (sum_r >= prev_r) begin
      cmd.gain = sum_r - prev_r;
      cmd.loss = '0;
    end else begin
      cmd.gain = '0;
      cmd.loss = prev_r - sum_r;
    end
    if (bar_count_r == '0) cmd.kind = hara_pkg::KIND_FIRST;
    else if (bar_count_r < n_eff) cmd.kind = hara_pkg::KIND_ACCUM;
    else if (bar_count_r == n_eff) cmd.kind = hara_pkg::KIND_INIT;
    else cmd.kind = hara_pkg::KIND_SMOOTH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      sum_r       <= '0;
      prev_r      <= '0;
      bar_count_r <= '0;
      len_r       <= hara_pkg::LEN_RESET;
      smo_r       <= hara_pkg::SMO_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hara_pkg::CFG_RSI_LENGTH:     len_r <= cfg_wdata;
          hara_pkg::CFG_OPEN_SMOOTHING: smo_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
        sum_r      <= sum_nxt;
      end else if (push) begin
        s1_valid_r <= 1'b0;
      end
      if (push) begin
        prev_r <= sum_r;
        if (bar_count_r != hara_pkg::COUNT_MAX) bar_count_r <= bar_count_r + 7'd1;
      end
    end
  end

endmodule

>>> rtl/hara_fifo.sv
// ----------------------------------------------------------------------------
// hara_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module hara_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hara_pkg::cmd_t cmd_in,
  output logic           full,
  input  logic           pop,
  output hara_pkg::cmd_t cmd_out,
  output logic           empty
);

  hara_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;

  assign full    = count_r == 2'd2;
  assign empty   = count_r == 2'd0;
  assign cmd_out = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> rtl/hara_back.sv
// ----------------------------------------------------------------------------
// hara_back
// averages, rsi and candle per command, result register
// ----------------------------------------------------------------------------
module hara_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          empty,
  input  hara_pkg::cmd_t                cmd,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_rsi_valid,
  output logic [hara_pkg::OUT_W-1:0]    out_rsi_open,
  output logic [hara_pkg::OUT_W-1:0]    out_rsi_high,
  output logic [hara_pkg::OUT_W-1:0]    out_rsi_low,
  output logic [hara_pkg::OUT_W-1:0]    out_rsi_close
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_SAT, ST_DIVG_GO, ST_DIVG_WT, ST_DIVL_GO, ST_DIVL_WT,
    ST_NORM, ST_RMUL, ST_RDIV_GO, ST_RDIV_WT, ST_OMUL, ST_OADD, ST_ODIV_GO,
    ST_ODIV_WT, ST_FIN
  } state_t;

  localparam logic signed [15:0] HALF = 16'sd12800;

  state_t                            state_r;
  hara_pkg::cmd_t                    cmd_r;
  logic                              zero_r;
  logic [hara_pkg::AVG_W-1:0]        ag_r, al_r, numg_r, numl_r, gs_r, ls_r;
  logic [63:0]                       prodg_r, prodl_r, rnum_r;
  logic [hara_pkg::NORM_BITS-1:0]    d_r;
  logic signed [15:0]                so_r, z_r, op_r;
  logic signed [23:0]                oprod_r, onum_r;
  logic [7:0]                        sdiv_r;
  logic                              out_valid_r, out_rsi_valid_r;
  logic [hara_pkg::OUT_W-1:0]        out_open_r, out_high_r, out_low_r, out_close_r;

  logic [hara_pkg::MOVE_W-1:0]       gmove, lmove;
  logic [hara_pkg::REG_W-1:0]        nm1;
  logic [hara_pkg::AVG_W:0]          glsum;
  logic [63:0]                       g64;
  logic                              div_start, div_done;
  logic [63:0]                       div_num, div_quot;
  logic [hara_pkg::NORM_BITS-1:0]    div_den;
  logic [6:0]                        div_nbits;
  logic signed [15:0]                hi, lo, qz;
  logic signed [18:0]                csum;
  logic signed [15:0]                cl;
  logic [21:0]                       obias;
  logic                              slot_free;

  assign gmove = {cmd_r.gain, {hara_pkg::FRAC_BITS{1'b0}}};
  assign lmove = {cmd_r.loss, {hara_pkg::FRAC_BITS{1'b0}}};
  assign nm1   = cmd_r.n - 7'd1;
  assign glsum = {1'b0, gs_r} + {1'b0, ls_r};
  assign g64   = 64'(gs_r);
  assign qz    = $signed({1'b0, div_quot[14:0]}) - HALF;
  assign obias = 22'(14'd12800 * sdiv_r);
  assign slot_free = !out_valid_r || !out_stall;
  assign pop   = (state_r == ST_IDLE) && !empty;

  always_comb begin
    hi   = (op_r > z_r) ? op_r : z_r;
    lo   = (op_r < z_r) ? op_r : z_r;
    csum = 19'(op_r) + 19'(hi) + 19'(lo) + 19'(z_r) + 19'sd51202;
    cl   = 16'(csum >>> 2) - HALF;
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = 64'(numg_r);
    div_den   = hara_pkg::NORM_BITS'(cmd_r.n);
    div_nbits = 7'(hara_pkg::AVG_W);
    case (state_r)
      ST_DIVG_GO: div_start = 1'b1;
      ST_DIVL_GO: begin
        div_start = 1'b1;
        div_num   = 64'(numl_r);
      end
      ST_RDIV_GO: begin
        div_start = 1'b1;
        div_num   = rnum_r;
        div_den   = d_r;
        div_nbits = 7'd63;
      end
      ST_ODIV_GO: begin
        div_start = 1'b1;
        div_num   = 64'(unsigned'(onum_r));
        div_den   = hara_pkg::NORM_BITS'(sdiv_r);
        div_nbits = 7'd24;
      end
      default: ;
    endcase
  end

  hara_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .nbits (div_nbits),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cmd_r <= '0;
      zero_r <= 1'b0;
      ag_r <= '0; al_r <= '0; numg_r <= '0; numl_r <= '0; gs_r <= '0; ls_r <= '0;
      prodg_r <= '0; prodl_r <= '0; rnum_r <= '0; d_r <= '0;
      so_r <= '0; z_r <= '0; op_r <= '0; oprod_r <= '0; onum_r <= '0; sdiv_r <= '0;
      out_valid_r <= 1'b0; out_rsi_valid_r <= 1'b0;
      out_open_r <= '0; out_high_r <= '0; out_low_r <= '0; out_close_r <= '0;
    end else begin
      // the finish state loads the next word itself
      if (out_valid_r && !out_stall && state_r != ST_FIN) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (!empty) begin
            cmd_r  <= cmd;
            zero_r <= 1'b0;
            case (cmd.kind)
              hara_pkg::KIND_FIRST: begin
                zero_r  <= 1'b1;
                state_r <= ST_FIN;
              end
              hara_pkg::KIND_ACCUM: begin
                ag_r <= hara_pkg::sat_avg(65'(ag_r)
                        + 65'({cmd.gain, {hara_pkg::FRAC_BITS{1'b0}}}));
                al_r <= hara_pkg::sat_avg(65'(al_r)
                        + 65'({cmd.loss, {hara_pkg::FRAC_BITS{1'b0}}}));
                so_r <= '0;
                zero_r  <= 1'b1;
                state_r <= ST_FIN;
              end
              hara_pkg::KIND_INIT: begin
                numg_r  <= hara_pkg::sat_avg(65'(ag_r)
                           + 65'({cmd.gain, {hara_pkg::FRAC_BITS{1'b0}}}));
                numl_r  <= hara_pkg::sat_avg(65'(al_r)
                           + 65'({cmd.loss, {hara_pkg::FRAC_BITS{1'b0}}}));
                state_r <= ST_DIVG_GO;
              end
              default: state_r <= ST_MUL;
            endcase
          end
        end
        ST_MUL: begin
          prodg_r <= 64'(ag_r) * 64'(nm1);
          prodl_r <= 64'(al_r) * 64'(nm1);
          state_r <= ST_SAT;
        end
        ST_SAT: begin
          numg_r  <= hara_pkg::sat_avg(65'(prodg_r) + 65'(gmove));
          numl_r  <= hara_pkg::sat_avg(65'(prodl_r) + 65'(lmove));
          state_r <= ST_DIVG_GO;
        end
        ST_DIVG_GO: state_r <= ST_DIVG_WT;
        ST_DIVG_WT: begin
          if (div_done) begin
            ag_r    <= div_quot[hara_pkg::AVG_W-1:0];
            state_r <= ST_DIVL_GO;
          end
        end
        ST_DIVL_GO: state_r <= ST_DIVL_WT;
        ST_DIVL_WT: begin
          if (div_done) begin
            al_r    <= div_quot[hara_pkg::AVG_W-1:0];
            gs_r    <= ag_r;
            ls_r    <= div_quot[hara_pkg::AVG_W-1:0];
            state_r <= ST_NORM;
          end
        end
        ST_NORM: begin
          // zero loss pins the rsi at the top
          if (al_r == '0) begin
            z_r     <= HALF;
            state_r <= (cmd_r.kind == hara_pkg::KIND_INIT) ? ST_FIN : ST_OMUL;
            if (cmd_r.kind == hara_pkg::KIND_INIT) op_r <= HALF;
          end else if (glsum[hara_pkg::AVG_W:hara_pkg::NORM_BITS] != '0) begin
            gs_r <= gs_r >> 1;
            ls_r <= ls_r >> 1;
          end else begin
            d_r     <= glsum[hara_pkg::NORM_BITS-1:0];
            state_r <= ST_RMUL;
          end
        end
        ST_RMUL: begin
          // 25600 = 2^14 + 2^13 + 2^10
          rnum_r  <= (g64 << 14) + (g64 << 13) + (g64 << 10) + 64'(d_r >> 1);
          state_r <= ST_RDIV_GO;
        end
        ST_RDIV_GO: state_r <= ST_RDIV_WT;
        ST_RDIV_WT: begin
          if (div_done) begin
            z_r <= qz;
            if (cmd_r.kind == hara_pkg::KIND_INIT) begin
              op_r    <= qz;
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_OMUL;
            end
          end
        end
        ST_OMUL: begin
          if (cmd_r.open_half) begin
            oprod_r <= 24'(so_r);
            sdiv_r  <= 8'd2;
          end else begin
            oprod_r <= 24'(so_r) * $signed({17'd0, cmd_r.s});
            sdiv_r  <= 8'(cmd_r.s) + 8'd1;
          end
          state_r <= ST_OADD;
        end
        ST_OADD: begin
          onum_r  <= oprod_r + 24'(z_r) + $signed({2'b0, obias})
                   + $signed({17'd0, sdiv_r[7:1]});
          state_r <= ST_ODIV_GO;
        end
        ST_ODIV_GO: state_r <= ST_ODIV_WT;
        ST_ODIV_WT: begin
          if (div_done) begin
            op_r    <= qz;
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            if (zero_r) begin
              out_rsi_valid_r <= 1'b0;
              out_open_r  <= '0;
              out_high_r  <= '0;
              out_low_r   <= '0;
              out_close_r <= '0;
            end else begin
              out_rsi_valid_r <= 1'b1;
              out_open_r  <= op_r[hara_pkg::OUT_W-1:0];
              out_high_r  <= hi[hara_pkg::OUT_W-1:0];
              out_low_r   <= lo[hara_pkg::OUT_W-1:0];
              out_close_r <= cl[hara_pkg::OUT_W-1:0];
              so_r        <= op_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rsi_valid = out_rsi_valid_r;
  assign out_rsi_open  = out_open_r;
  assign out_rsi_high  = out_high_r;
  assign out_rsi_low   = out_low_r;
  assign out_rsi_close = out_close_r;

endmodule
